/* src/stereo_sliding_median_defines.svh */
// ----------------------------------------------------------------------------
// stereo_sliding_median_defines : assertion macros
// Clocked on clk; the reset-gated form is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_SLIDING_MEDIAN_DEFINES_SVH
`define STEREO_SLIDING_MEDIAN_DEFINES_SVH

// checked only out of reset
`define SSM_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SSM_ASSERT_ANY(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ssm_pkg.sv */
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared constants and types of the stereo sliding median filter.
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int MAX_HALF    = 7;
    localparam int SAMPLE_BITS = 16;
    localparam int WIN_DEPTH   = 2 * MAX_HALF + 1;
    localparam int IDX_BITS    = $clog2(WIN_DEPTH + 1);
    localparam int HALF_BITS   = 3;
    localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(1);

    typedef logic signed [SAMPLE_BITS-1:0] pcm_t;
    typedef logic [IDX_BITS-1:0]           idx_t;

    typedef struct packed {
        pcm_t right;
        pcm_t left;
    } pair_t;

    typedef struct packed {
        pair_t data;
        idx_t  idx;
    } probe_t;

    typedef struct packed {
        logic load;
        logic step;
        idx_t win_len;
        idx_t half;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

endpackage

/* src/ssm_cell.sv */
// ----------------------------------------------------------------------------
// ssm_cell
// One window slot: holds a stereo sample, counts its rank against a ring of
// circulating probes, and flags itself when it holds the median.
// ----------------------------------------------------------------------------
module ssm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  ssm_pkg::cell_ctl_t ctl,
    input  ssm_pkg::idx_t      my_idx,
    input  ssm_pkg::pair_t     sample_in,
    input  ssm_pkg::probe_t    probe_in,
    output ssm_pkg::pair_t     sample_out,
    output ssm_pkg::probe_t    probe_out,
    output logic               hit_l,
    output logic               hit_r
);

    ssm_pkg::pair_t  sample_reg;
    ssm_pkg::probe_t probe_reg;
    ssm_pkg::idx_t   cnt_l_reg, cnt_l_next;
    ssm_pkg::idx_t   cnt_r_reg, cnt_r_next;
    logic            probe_active;
    logic            earlier;
    logic            less_l, less_r;

    assign probe_active = (probe_reg.idx < ctl.win_len);
    assign earlier      = (probe_reg.idx < my_idx);

    // strict order with ties broken by window position
    assign less_l = (probe_reg.data.left < sample_reg.left) ||
                    ((probe_reg.data.left == sample_reg.left) && earlier);
    assign less_r = (probe_reg.data.right < sample_reg.right) ||
                    ((probe_reg.data.right == sample_reg.right) && earlier);

    always_comb
    begin
        cnt_l_next = cnt_l_reg;
        cnt_r_next = cnt_r_reg;
        if (ctl.load)
        begin
            cnt_l_next = '0;
            cnt_r_next = '0;
        end
        else if (ctl.step && probe_active)
        begin
            cnt_l_next = cnt_l_reg + ssm_pkg::idx_t'(less_l);
            cnt_r_next = cnt_r_reg + ssm_pkg::idx_t'(less_r);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            cnt_l_reg  <= '0;
            cnt_r_reg  <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                sample_reg <= sample_in;
            end
            cnt_l_reg <= cnt_l_next;
            cnt_r_reg <= cnt_r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            probe_reg.data <= sample_in;
            probe_reg.idx  <= my_idx;
        end
        else if (ctl.step)
        begin
            probe_reg <= probe_in;
        end
    end

    assign sample_out = sample_reg;
    assign probe_out  = probe_reg;
    assign hit_l      = (my_idx < ctl.win_len) && (cnt_l_reg == ctl.half);
    assign hit_r      = (my_idx < ctl.win_len) && (cnt_r_reg == ctl.half);

endmodule

/* src/stereo_sliding_median.sv */
// ----------------------------------------------------------------------------
// stereo_sliding_median: per-channel median of the last 2*half_length+1 samples
// Flow: an input transfer loads the window, the probe ring steps through the 15 slots in S_RUN,
// and S_DONE registers the median once the output is free; input waits until then (S_IDLE only).
// Reset: window cleared to zero, half_length set to 1, output empty.
// ----------------------------------------------------------------------------
`include "stereo_sliding_median_defines.svh"

module stereo_sliding_median (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,       // half_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [15:0] left_in, [31:16] right_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata     // [15:0] left_median, [31:16] right_median
);

    localparam int WD = ssm_pkg::WIN_DEPTH;

    ssm_pkg::state_t                    state_reg, state_next;
    ssm_pkg::idx_t                      step_cnt_reg, step_cnt_next;
    logic [ssm_pkg::HALF_BITS-1:0]      half_reg;
    logic [ssm_pkg::HALF_BITS-1:0]      half_sat;
    logic                               out_valid_reg, out_valid_next;
    ssm_pkg::pair_t                     out_data_reg;
    ssm_pkg::pair_t                     median;
    ssm_pkg::cell_ctl_t                 ctl;
    ssm_pkg::pair_t                     in_pair;
    ssm_pkg::pair_t                     sample_chain [WD];
    ssm_pkg::probe_t                    probe_ring   [WD];
    logic [WD-1:0]                      hit_l_vec;
    logic [WD-1:0]                      hit_r_vec;
    logic                               in_xfer;
    logic                               out_load;

    assign in_pair.left  = s_axis_tdata[15:0];
    assign in_pair.right = s_axis_tdata[31:16];

    assign half_sat = (half_reg > ssm_pkg::HALF_BITS'(ssm_pkg::MAX_HALF)) ?
                      ssm_pkg::HALF_BITS'(ssm_pkg::MAX_HALF) : half_reg;

    assign s_axis_tready = (state_reg == ssm_pkg::S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ssm_pkg::S_DONE) && (!out_valid_reg || m_axis_tready);

    assign ctl.load    = in_xfer;
    assign ctl.step    = (state_reg == ssm_pkg::S_RUN);
    assign ctl.win_len = ssm_pkg::idx_t'({half_sat, 1'b1});
    assign ctl.half    = ssm_pkg::idx_t'(half_sat);

    genvar gi;
    generate
        for (gi = 0; gi < WD; gi++)
        begin : g_cell
            ssm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .my_idx     (ssm_pkg::idx_t'(gi)),
                .sample_in  ((gi == 0) ? in_pair : sample_chain[(gi == 0) ? 0 : gi - 1]),
                .probe_in   (probe_ring[(gi + 1) % WD]),
                .sample_out (sample_chain[gi]),
                .probe_out  (probe_ring[gi]),
                .hit_l      (hit_l_vec[gi]),
                .hit_r      (hit_r_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        median = '0;
        for (int i = 0; i < WD; i++)
        begin
            if (hit_l_vec[i])
            begin
                median.left = median.left | sample_chain[i].left;
            end
            if (hit_r_vec[i])
            begin
                median.right = median.right | sample_chain[i].right;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ssm_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next    = ssm_pkg::S_RUN;
                    step_cnt_next = '0;
                end
            end
            ssm_pkg::S_RUN:
            begin
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == ssm_pkg::idx_t'(WD - 1))
                begin
                    state_next    = ssm_pkg::S_DONE;
                    step_cnt_next = '0;
                end
            end
            ssm_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ssm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ssm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssm_pkg::S_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            half_reg      <= ssm_pkg::HALF_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                half_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= median;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.right, out_data_reg.left};

    `SSM_ASSERT_RST(a_one_median, (state_reg == ssm_pkg::S_DONE) |-> ($onehot(hit_l_vec) && $onehot(hit_r_vec)), "median select not unique")
    `SSM_ASSERT_RST(a_start_run, in_xfer |=> (state_reg == ssm_pkg::S_RUN && step_cnt_reg == '0), "transfer did not start probe run")
    `SSM_ASSERT_RST(a_step_bound, step_cnt_reg <= ssm_pkg::idx_t'(WD - 1), "probe step count out of range")
    `SSM_ASSERT_RST(a_out_src, $rose(m_axis_tvalid) |-> $past(state_reg == ssm_pkg::S_DONE), "result without finished run")

endmodule

/* bench/stereo_sliding_median_test.sv */
// ----------------------------------------------------------------------------
// stereo_sliding_median_test
// Drives stereo pairs into the median filter under random source gaps and
// sink stalls, and predicts each channel's window median from its own copy
// of the sample history and length setting. Every output transfer is
// checked against the oldest prediction, one channel at a time.
// ----------------------------------------------------------------------------
module stereo_sliding_median_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int            RUN_LIMIT   = 400000;
    localparam int            DRAIN_WAIT  = 40;
    localparam int            HOLD_CYCLES = 400;
    localparam ssm_pkg::pcm_t S_MAX       = 16'sh7FFF;
    localparam ssm_pkg::pcm_t S_MIN       = 16'sh8000;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          cfg_we        = 1'b0;
    logic [ssm_pkg::HALF_BITS-1:0] cfg_wdata     = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [31:0]                   s_axis_tdata  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [31:0]                   m_axis_tdata;

    logic [ssm_pkg::WIN_DEPTH*ssm_pkg::SAMPLE_BITS-1:0] left_hist;
    logic [ssm_pkg::WIN_DEPTH*ssm_pkg::SAMPLE_BITS-1:0] right_hist;
    logic [ssm_pkg::HALF_BITS-1:0]                      half_model;
    ssm_pkg::pair_t                                     median_q[$];

    bit idle_on     = 1'b0;
    int sink_hold   = 0;
    int pairs_in    = 0;
    int medians_ok  = 0;
    int half_writes = 0;
    int errors      = 0;
    int cycle_cnt   = 0;

    stereo_sliding_median i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // median of the newest 2*h+1 entries, entry 0 in the low bits
    function automatic ssm_pkg::pcm_t window_median(
        input logic [ssm_pkg::WIN_DEPTH*ssm_pkg::SAMPLE_BITS-1:0] hist,
        input int h
    );
        ssm_pkg::pcm_t sorted[ssm_pkg::WIN_DEPTH];
        ssm_pkg::pcm_t v;
        int            n;
        int            j;
        n = 2 * h + 1;
        for (int i = 0; i < n; i++)
        begin
            v = hist[i*ssm_pkg::SAMPLE_BITS +: ssm_pkg::SAMPLE_BITS];
            j = i;
            while (j > 0 && sorted[j-1] > v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[h];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : median_tracker
        ssm_pkg::pair_t pair;
        ssm_pkg::pair_t want;
        int             h;
        if (!rst_n)
        begin
            left_hist  = '0;
            right_hist = '0;
            half_model = ssm_pkg::HALF_RESET;
        end
        else
        begin
            if (cfg_we)
                half_model = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                pair       = s_axis_tdata;
                left_hist  = {left_hist[(ssm_pkg::WIN_DEPTH-1)*ssm_pkg::SAMPLE_BITS-1:0],
                              pair.left};
                right_hist = {right_hist[(ssm_pkg::WIN_DEPTH-1)*ssm_pkg::SAMPLE_BITS-1:0],
                              pair.right};
                h          = (half_model > ssm_pkg::MAX_HALF) ? ssm_pkg::MAX_HALF : half_model;
                want.left  = window_median(left_hist, h);
                want.right = window_median(right_hist, h);
                median_q.push_back(want);
                pairs_in++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                pair = m_axis_tdata;
                if (median_q.size() == 0)
                begin
                    $display("%0t: unexpected output transfer, actual left %0d right %0d",
                             $realtime, pair.left, pair.right);
                    errors++;
                end
                else
                begin
                    want = median_q.pop_front();
                    if (pair.left !== want.left)
                    begin
                        $display("%0t: left_median expected %0d actual %0d",
                                 $realtime, want.left, pair.left);
                        errors++;
                    end
                    if (pair.right !== want.right)
                    begin
                        $display("%0t: right_median expected %0d actual %0d",
                                 $realtime, want.right, pair.right);
                        errors++;
                    end
                    medians_ok++;
                end
            end
        end
    end

    // sink side: long hold on request, short random stalls while idle_on is set
    always
    begin
        @(posedge clk);
        if (sink_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            repeat (sink_hold) @(posedge clk);
            sink_hold = 0;
            m_axis_tready <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
            m_axis_tready <= 1'b1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin : watchdog
        while (cycle_cnt < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("%0t: timeout after %0d cycles, %0d medians pending",
                 $realtime, cycle_cnt, median_q.size());
        $display("tb: failure");
        $finish;
    end

    task automatic send_pair(input ssm_pkg::pcm_t l, input ssm_pkg::pcm_t r);
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r, l};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (median_q.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_half(input logic [ssm_pkg::HALF_BITS-1:0] h);
        cfg_we    <= 1'b1;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        half_writes++;
    endtask

    // reset length, zeros from reset inside the first windows
    task automatic test_stream_start();
        idle_on = 1'b0;
        send_pair(16'sd1000, -16'sd1000);
        send_pair(S_MAX, S_MIN);
        send_pair(S_MIN, S_MAX);
        send_pair(-16'sd1, 16'sd1);
        send_pair(16'sd5, 16'sd5);
        settle();
    endtask

    task automatic test_extremes();
        set_half(3'd7);
        for (int i = 0; i < 8; i++)
            send_pair(i[0] ? S_MAX : S_MIN, ssm_pkg::pcm_t'((i < 4) ? -16'sd1 : S_MAX - i));
        settle();
    endtask

    // history survives a length change
    task automatic test_length_change();
        set_half(3'd0);
        send_pair(16'sd300, -16'sd300);
        send_pair(S_MIN, S_MAX);
        send_pair(16'sd0, 16'sd0);
        settle();
        set_half(3'd4);
        send_pair(16'sd7, -16'sd7);
        send_pair(-16'sd2, 16'sd2);
        send_pair(S_MAX, S_MIN);
        settle();
    endtask

    task automatic test_backpressure();
        idle_on   = 1'b1;
        set_half(3'd2);
        sink_hold = HOLD_CYCLES;
        repeat (12) send_pair(ssm_pkg::pcm_t'($urandom), ssm_pkg::pcm_t'($urandom));
        settle();
    endtask

    task automatic test_random();
        int            fixed_half[6] = '{7, 0, 3, 1, 7, 0};
        int            mode;
        ssm_pkg::pcm_t base_l;
        ssm_pkg::pcm_t base_r;
        ssm_pkg::pcm_t l;
        ssm_pkg::pcm_t r;
        base_l = '0;
        base_r = '0;
        for (int p = 0; p < 12; p++)
        begin
            idle_on = (p < 9);
            set_half(ssm_pkg::HALF_BITS'((p < 6) ? fixed_half[p] :
                                         $urandom_range(0, ssm_pkg::MAX_HALF)));
            for (int k = 0; k < 100; k++)
            begin
                mode = $urandom_range(0, 9);
                if (mode < 4)
                begin
                    l = ssm_pkg::pcm_t'($urandom);
                    r = ssm_pkg::pcm_t'($urandom);
                end
                else if (mode < 6)
                begin
                    // narrow range, many ties
                    l = ssm_pkg::pcm_t'($urandom_range(0, 6)) - 16'sd3;
                    r = ssm_pkg::pcm_t'($urandom_range(0, 6)) - 16'sd3;
                end
                else if (mode == 6)
                begin
                    l = $urandom_range(0, 1) ? S_MAX : S_MIN;
                    r = $urandom_range(0, 1) ? ssm_pkg::pcm_t'(-16'sd1) : ssm_pkg::pcm_t'(16'sd0);
                end
                else
                begin
                    // slow drift with the odd impulse
                    base_l = base_l + ssm_pkg::pcm_t'($urandom_range(0, 64)) - 16'sd32;
                    base_r = base_r + ssm_pkg::pcm_t'($urandom_range(0, 64)) - 16'sd32;
                    l = ($urandom_range(0, 7) == 0) ? ssm_pkg::pcm_t'($urandom) : base_l;
                    r = ($urandom_range(0, 7) == 0) ? ssm_pkg::pcm_t'($urandom) : base_r;
                end
                send_pair(l, r);
            end
            settle();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stream_start();
        test_extremes();
        test_length_change();
        test_backpressure();
        test_random();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("summary: %0d pairs in, %0d medians checked, %0d errors",
                 pairs_in, medians_ok, errors);
        $display("summary: %0d length writes over 0..7, one sink hold of %0d cycles",
                 half_writes, HOLD_CYCLES);
        if (errors == 0 && median_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
